### rtl/dpcm_pkg.sv
// ----------------------------------------------------------------------------
// dpcm_pkg
// Shared constants, codes and types of the DPCM packed-code audio decoder.
// ----------------------------------------------------------------------------
package dpcm_pkg;

    // Bits per code (2 to 4).
    localparam int unsigned CODE_BITS  = 4;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned COUNT_W    = 24;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned TBL_WORDS  = 4;
    localparam int unsigned TBL_PER_W  = 4;
    localparam int unsigned TBL_SIZE   = TBL_WORDS * TBL_PER_W;
    localparam int unsigned TBL_IDX_W  = $clog2(TBL_SIZE);

    // Accumulator holds the leftover bits of the last word plus a new word.
    localparam int unsigned ACC_W      = WORD_BITS + CODE_BITS - 1;
    localparam int unsigned AVAIL_W    = $clog2(ACC_W + 1);
    localparam int unsigned RES_W      = $clog2(CODE_BITS);

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_WORD  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_SILENCE = 3'd0,
        REG_DELTA_A = 3'd1,
        REG_DELTA_B = 3'd2,
        REG_DELTA_C = 3'd3,
        REG_DELTA_D = 3'd4
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef logic [TBL_SIZE-1:0][SAMPLE_W-1:0] t_delta_tbl;

    typedef struct packed {
        logic start;
        logic word;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic playing;
        logic out_free;
        logic step_last;
    } t_dp_sts;

endpackage

### rtl/dpcm_if.sv
// ----------------------------------------------------------------------------
// dpcm_if
// Valid/ready channels for the decoder's input items and result items.
// ----------------------------------------------------------------------------
interface dpcm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [dpcm_pkg::COUNT_W-1:0]      sample_count;
    logic [dpcm_pkg::WORD_BITS-1:0]    packed_word;

    modport source (output valid, func, sample_count, packed_word, input ready);
    modport sink   (input valid, func, sample_count, packed_word, output ready);
endinterface

interface dpcm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dpcm_pkg::SAMPLE_W-1:0] sample_value;
    logic                              last;
    logic                              sound_done;

    modport source (output valid, sample_value, last, sound_done, input ready);
    modport sink   (input valid, sample_value, last, sound_done, output ready);
endinterface

### rtl/dpcm_regs.sv
// ----------------------------------------------------------------------------
// dpcm_regs
// APB register file: silence level and the four dequantization table words.
// ----------------------------------------------------------------------------
module dpcm_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dpcm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dpcm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [dpcm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [dpcm_pkg::SAMPLE_W-1:0]      o_silence,
    output dpcm_pkg::t_delta_tbl               o_delta_tbl
);

    logic [dpcm_pkg::SAMPLE_W-1:0]   r_silence;
    logic [dpcm_pkg::CFG_DATA_W-1:0] r_delta [dpcm_pkg::TBL_WORDS];
    logic                            wr_en;
    dpcm_pkg::t_reg_idx              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = dpcm_pkg::t_reg_idx'(paddr[dpcm_pkg::CFG_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= '0;
            for (int w = 0; w < dpcm_pkg::TBL_WORDS; w++) begin
                r_delta[w] <= '0;
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                dpcm_pkg::REG_SILENCE: r_silence  <= pwdata[dpcm_pkg::SAMPLE_W-1:0];
                dpcm_pkg::REG_DELTA_A: r_delta[0] <= pwdata;
                dpcm_pkg::REG_DELTA_B: r_delta[1] <= pwdata;
                dpcm_pkg::REG_DELTA_C: r_delta[2] <= pwdata;
                dpcm_pkg::REG_DELTA_D: r_delta[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dpcm_pkg::REG_SILENCE: prdata = dpcm_pkg::CFG_DATA_W'(r_silence);
            dpcm_pkg::REG_DELTA_A: prdata = r_delta[0];
            dpcm_pkg::REG_DELTA_B: prdata = r_delta[1];
            dpcm_pkg::REG_DELTA_C: prdata = r_delta[2];
            dpcm_pkg::REG_DELTA_D: prdata = r_delta[3];
            default:               prdata = '0;
        endcase
    end

    // Code k sits in word k/4, lane k%4, lowest lane in the low bits.
    always_comb begin
        for (int w = 0; w < dpcm_pkg::TBL_WORDS; w++) begin
            for (int k = 0; k < dpcm_pkg::TBL_PER_W; k++) begin
                o_delta_tbl[w*dpcm_pkg::TBL_PER_W + k] =
                    r_delta[w][k*dpcm_pkg::SAMPLE_W +: dpcm_pkg::SAMPLE_W];
            end
        end
    end

    assign o_silence = r_silence;

endmodule

### rtl/dpcm_ctrl.sv
// ----------------------------------------------------------------------------
// dpcm_ctrl
// Controller: takes input items while idle and steps the datapath through
// the codes of a word, one code per cycle while the output can take it.
// ----------------------------------------------------------------------------
module dpcm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_func,
    input  dpcm_pkg::t_dp_sts    i_sts,
    output logic                 o_in_ready,
    output dpcm_pkg::t_dp_cmd    o_cmd
);

    dpcm_pkg::t_state r_state;
    dpcm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            dpcm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func == dpcm_pkg::FUNC_START) begin
                        o_cmd.start = 1'b1;
                    end else if (i_sts.playing) begin
                        // A word while no sound is playing is dropped without effect.
                        o_cmd.word = 1'b1;
                        n_state    = dpcm_pkg::ST_RUN;
                    end
                end
            end
            dpcm_pkg::ST_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.step_last) begin
                        n_state = dpcm_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = dpcm_pkg::ST_IDLE;
        endcase
    end

endmodule

### rtl/dpcm_dp.sv
// ----------------------------------------------------------------------------
// dpcm_dp
// Datapath: code accumulator, predictor, sample counters and the output
// register.
// ----------------------------------------------------------------------------
module dpcm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dpcm_pkg::t_dp_cmd                    i_cmd,
    output dpcm_pkg::t_dp_sts                    o_sts,
    input  logic [dpcm_pkg::COUNT_W-1:0]         i_sample_count,
    input  logic [dpcm_pkg::WORD_BITS-1:0]       i_packed_word,
    input  logic [dpcm_pkg::SAMPLE_W-1:0]        i_silence,
    input  dpcm_pkg::t_delta_tbl                 i_delta_tbl,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [dpcm_pkg::SAMPLE_W-1:0] o_sample_value,
    output logic                                 o_last,
    output logic                                 o_sound_done
);

    logic [dpcm_pkg::SAMPLE_W-1:0] r_pred;
    logic [dpcm_pkg::ACC_W-1:0]    r_acc;
    logic [dpcm_pkg::AVAIL_W-1:0]  r_avail;
    logic [dpcm_pkg::COUNT_W-1:0]  r_done;
    logic [dpcm_pkg::COUNT_W-1:0]  r_total;
    logic                          r_playing;
    logic                          r_out_valid;
    logic [dpcm_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_out_last;
    logic                          r_out_done;

    logic [dpcm_pkg::CODE_BITS-1:0] code;
    logic [dpcm_pkg::SAMPLE_W-1:0]  pred_next;
    logic [dpcm_pkg::COUNT_W-1:0]   done_next;
    logic [dpcm_pkg::AVAIL_W-1:0]   avail_next;
    logic                           sound_end;
    logic                           word_end;
    logic [dpcm_pkg::RES_W-1:0]     res_cnt;
    logic [dpcm_pkg::ACC_W-1:0]     acc_load;

    assign code       = r_acc[dpcm_pkg::CODE_BITS-1:0];
    assign pred_next  = r_pred + i_delta_tbl[dpcm_pkg::TBL_IDX_W'(code)];
    assign done_next  = r_done + dpcm_pkg::COUNT_W'(1);
    assign avail_next = r_avail - dpcm_pkg::AVAIL_W'(dpcm_pkg::CODE_BITS);
    assign sound_end  = (done_next == r_total);
    assign word_end   = (avail_next < dpcm_pkg::AVAIL_W'(dpcm_pkg::CODE_BITS));

    // Between words the accumulator holds fewer bits than one code, low
    // aligned and zero above; the new word lands right above them.
    assign res_cnt  = r_avail[dpcm_pkg::RES_W-1:0];
    assign acc_load = r_acc | (dpcm_pkg::ACC_W'(i_packed_word) << res_cnt);

    assign o_sts.playing   = r_playing;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.step_last = sound_end || word_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred      <= '0;
            r_acc       <= '0;
            r_avail     <= '0;
            r_done      <= '0;
            r_total     <= '0;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.start) begin
                r_total   <= i_sample_count;
                r_done    <= '0;
                r_acc     <= '0;
                r_avail   <= '0;
                r_pred    <= i_silence;
                r_playing <= (i_sample_count != '0);
            end else if (i_cmd.word) begin
                r_acc   <= acc_load;
                r_avail <= dpcm_pkg::AVAIL_W'(res_cnt)
                         + dpcm_pkg::AVAIL_W'(dpcm_pkg::WORD_BITS);
            end else if (i_cmd.step) begin
                r_pred <= pred_next;
                r_done <= done_next;
                if (sound_end) begin
                    // Bits left in the word are dropped once the sound ends.
                    r_playing <= 1'b0;
                    r_acc     <= '0;
                    r_avail   <= '0;
                end else begin
                    r_acc   <= r_acc >> dpcm_pkg::CODE_BITS;
                    r_avail <= avail_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_sample <= pred_next;
            r_out_last   <= sound_end || word_end;
            r_out_done   <= sound_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_sample;
    assign o_last         = r_out_last;
    assign o_sound_done   = r_out_done;

endmodule

### rtl/dpcm_packed_code_audio_decoder.sv
// ----------------------------------------------------------------------------
// dpcm_packed_code_audio_decoder
// DPCM audio decoder for words of packed codes, with an APB register port.
// ----------------------------------------------------------------------------
// A start item (func 0) produces nothing; it loads the sample count and
// sets the predictor to the silence level. A word item (func 1) is taken,
// after which the datapath adds one table delta per cycle, so a word
// yields its samples (up to (32 + CODE_BITS - 1) / CODE_BITS, eight at four
// bits per code) on consecutive cycles while the output is being taken;
// the next item is accepted only after the word's last sample has been
// produced, since the single predictor adder steps through the codes one
// at a time. Registers sit at byte address 8 * index with 64-bit data, and
// should be written while idle.
module dpcm_packed_code_audio_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dpcm_in_if.sink                         i_in,
    dpcm_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpcm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dpcm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dpcm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [dpcm_pkg::SAMPLE_W-1:0] silence;
    dpcm_pkg::t_delta_tbl          delta_tbl;
    dpcm_pkg::t_dp_cmd             dp_cmd;
    dpcm_pkg::t_dp_sts             dp_sts;
    logic                          in_ready;

    dpcm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_silence   (silence),
        .o_delta_tbl (delta_tbl)
    );

    dpcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.func),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    dpcm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_sample_count (i_in.sample_count),
        .i_packed_word  (i_in.packed_word),
        .i_silence      (silence),
        .i_delta_tbl    (delta_tbl),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_sample_value (o_out.sample_value),
        .o_last         (o_out.last),
        .o_sound_done   (o_out.sound_done)
    );

    assign i_in.ready = in_ready;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DPCM packed-code audio decoder. Start and word
// items go in on a valid/ready channel, and every decoded sample that comes
// out is compared with a software decoder that follows the same state. The
// register port sets the silence level and the delta table between phases,
// and in some phases both channel sides stall at random.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [dpcm_pkg::SAMPLE_W-1:0] sample_value;
    logic                                 last;
    logic                                 sound_done;
} t_decoded_sample;

// Decodes the accepted items in software and holds the samples still owed.
class sample_predictor;
    logic [dpcm_pkg::SAMPLE_W-1:0]  silence_level;
    logic [63:0]                    delta_word [dpcm_pkg::TBL_WORDS];
    logic [dpcm_pkg::SAMPLE_W-1:0]  pred_value;
    logic [dpcm_pkg::WORD_BITS-1:0] res_bits;
    logic [2:0]                     res_count;
    logic [dpcm_pkg::COUNT_W-1:0]   samples_done;
    logic [dpcm_pkg::COUNT_W-1:0]   samples_total;
    bit                             playing;
    t_decoded_sample                expected_samples [$];
    int                             errors;

    function new();
        silence_level = '0;
        foreach (delta_word[i]) delta_word[i] = '0;
        pred_value    = '0;
        res_bits      = '0;
        res_count     = '0;
        samples_done  = '0;
        samples_total = '0;
        playing       = 1'b0;
        errors        = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            dpcm_pkg::REG_SILENCE: silence_level = value[dpcm_pkg::SAMPLE_W-1:0];
            dpcm_pkg::REG_DELTA_A: delta_word[0] = value;
            dpcm_pkg::REG_DELTA_B: delta_word[1] = value;
            dpcm_pkg::REG_DELTA_C: delta_word[2] = value;
            dpcm_pkg::REG_DELTA_D: delta_word[3] = value;
            default: ;
        endcase
    endfunction

    // Returns 1 unless the item is a word that the decoder ignores.
    function bit take_item(logic func, logic [dpcm_pkg::COUNT_W-1:0] count,
                           logic [dpcm_pkg::WORD_BITS-1:0] word);
        logic [63:0]     acc;
        logic [3:0]      code;
        int              avail;
        int              pos;
        int              left;
        int              n;
        t_decoded_sample smp;
        if (func == dpcm_pkg::FUNC_START) begin
            samples_total = count;
            samples_done  = '0;
            res_bits      = '0;
            res_count     = '0;
            pred_value    = silence_level;
            playing       = (count != 0);
            return 1'b1;
        end
        if (!playing)
            return 1'b0;
        acc   = 64'(res_bits) | (64'(word) << res_count);
        avail = int'(res_count) + int'(dpcm_pkg::WORD_BITS);
        pos   = 0;
        n     = 0;
        while ((avail - pos) >= int'(dpcm_pkg::CODE_BITS) && samples_done < samples_total) begin
            code             = 4'((acc >> pos) & ((64'd1 << dpcm_pkg::CODE_BITS) - 1));
            pos              = pos + int'(dpcm_pkg::CODE_BITS);
            pred_value       = pred_value + delta_word[code[3:2]][16*code[1:0] +: 16];
            samples_done     = samples_done + 1'b1;
            smp.sample_value = pred_value;
            smp.last         = 1'b0;
            smp.sound_done   = (samples_done == samples_total);
            expected_samples.push_back(smp);
            n++;
        end
        if (n > 0)
            expected_samples[expected_samples.size()-1].last = 1'b1;
        if (samples_done >= samples_total) begin
            playing   = 1'b0;
            res_bits  = '0;
            res_count = '0;
        end else begin
            left      = avail - pos;
            res_count = 3'(left);
            res_bits  = 32'((acc >> pos) & ((64'd1 << left) - 1));
        end
        return 1'b1;
    endfunction

    function void flag(string what, longint want, longint got);
        if (errors < 30)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        errors++;
    endfunction

    function void check_sample(logic signed [dpcm_pkg::SAMPLE_W-1:0] value, logic last,
                               logic done);
        t_decoded_sample want;
        if (expected_samples.size() == 0) begin
            if (errors < 30)
                $display("%0t: sample %0d arrived with none expected: expected nothing, actual %0d",
                         $time, value, value);
            errors++;
            return;
        end
        want = expected_samples.pop_front();
        if (value !== want.sample_value)
            flag("sample_value", want.sample_value, value);
        if (last !== want.last)
            flag("last", want.last, last);
        if (done !== want.sound_done)
            flag("sound_done", want.sound_done, done);
    endfunction
endclass

module testbench;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEG_ITEMS     = 28;
    localparam logic [2:0] REG_NONE = 3'd5;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dpcm_pkg::CFG_ADDR_W-1:0] paddr;
    logic [dpcm_pkg::CFG_DATA_W-1:0] pwdata;
    logic [dpcm_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    dpcm_in_if  in_ch ();
    dpcm_out_if out_ch ();

    sample_predictor board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int useful_items  = 0;

    dpcm_packed_code_audio_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
                repeat (hold) begin
                    out_ch.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_sample(out_ch.sample_value, out_ch.last, out_ch.sound_done);
    end

    task automatic send_item(logic func, logic [dpcm_pkg::COUNT_W-1:0] count,
                             logic [dpcm_pkg::WORD_BITS-1:0] word);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.func         <= func;
        in_ch.sample_count <= count;
        in_ch.packed_word  <= word;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (board.take_item(func, count, word))
            useful_items++;
    endtask

    task automatic start_sound(logic [dpcm_pkg::COUNT_W-1:0] count);
        send_item(dpcm_pkg::FUNC_START, count, $urandom);
    endtask

    task automatic send_word(logic [dpcm_pkg::WORD_BITS-1:0] word);
        send_item(dpcm_pkg::FUNC_WORD, 24'($urandom), word);
    endtask

    // Stop offering items and wait until every owed sample is out and the
    // datapath has had time to finish a word that produced nothing.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(int seg);
        logic [15:0] level;
        logic [63:0] tbl [dpcm_pkg::TBL_WORDS];
        case (seg)
            0: begin
                level = 16'h7FFF;
                foreach (tbl[i]) tbl[i] = {4{16'h7FFF}};
            end
            1: begin
                level = 16'h8000;
                foreach (tbl[i]) tbl[i] = {4{16'h8000}};
            end
            2: begin
                level = 16'hFFFF;
                foreach (tbl[i]) tbl[i] = '1;
            end
            3: begin
                level = 16'h0000;
                foreach (tbl[i]) tbl[i] = '0;
            end
            default: begin
                level = 16'($urandom);
                foreach (tbl[i]) tbl[i] = {$urandom, $urandom};
            end
        endcase
        cfg_write(dpcm_pkg::REG_SILENCE, {$urandom, 16'($urandom), level});
        cfg_write(dpcm_pkg::REG_DELTA_A, tbl[0]);
        cfg_write(dpcm_pkg::REG_DELTA_B, tbl[1]);
        cfg_write(dpcm_pkg::REG_DELTA_C, tbl[2]);
        cfg_write(dpcm_pkg::REG_DELTA_D, tbl[3]);
    endtask

    // One sound with random content; some are cut short by the next start,
    // some run on past their end, and a few are preceded by stray words.
    task automatic run_sound();
        logic [dpcm_pkg::COUNT_W-1:0] count;
        int need;
        int r;
        r = int'($urandom_range(99));
        if (r < 6)
            repeat ($urandom_range(1, 3)) send_word($urandom);
        r = int'($urandom_range(99));
        if (r < 80)
            count = 24'($urandom_range(1, 40));
        else if (r < 87)
            count = '0;
        else if (r < 94)
            count = 24'($urandom_range(41, 200));
        else
            count = 24'($urandom_range(0, 24'hFFFFFF));
        start_sound(count);
        need = (int'(count) * int'(dpcm_pkg::CODE_BITS) + int'(dpcm_pkg::WORD_BITS) - 1)
               / int'(dpcm_pkg::WORD_BITS);
        if (need > 25)
            need = int'($urandom_range(1, 6));
        if ($urandom_range(99) < 10)
            need = int'($urandom_range(0, need));
        need = need + int'($urandom_range(0, 1));
        repeat (need) send_word($urandom);
        if ($urandom_range(99) < 10)
            drain();
    endtask

    initial begin
        int seg_start;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = dpcm_pkg::FUNC_START;
        in_ch.sample_count = '0;
        in_ch.packed_word  = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A word straight after reset finds the decoder idle.
        send_word(32'hFFFF_FFFF);
        drain();
        cfg_write(dpcm_pkg::REG_SILENCE, 64'h0000_0000_0000_1234);
        cfg_write(dpcm_pkg::REG_DELTA_A, 64'h8000_7FFF_0001_0000);
        cfg_write(dpcm_pkg::REG_DELTA_B, 64'h0100_FF00_1234_FFFF);
        cfg_write(dpcm_pkg::REG_DELTA_C, 64'hC000_4000_00FF_EDCB);
        cfg_write(dpcm_pkg::REG_DELTA_D, 64'h0010_FFF0_0200_FE00);
        cfg_write(REG_NONE, '1);

        // A zero-length sound leaves the decoder idle, so the word is dropped.
        send_item(dpcm_pkg::FUNC_START, 24'h000000, 32'hFFFF_FFFF);
        send_word(32'h7654_3210);
        // Every code once, the sound ending exactly on the last code.
        start_sound(24'd16);
        send_word(32'h7654_3210);
        send_word(32'hFEDC_BA98);
        // The sound ends inside a word; the rest of it and the next are dropped.
        start_sound(24'd3);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        // Longest sound, restarted before it ends.
        send_item(dpcm_pkg::FUNC_START, 24'hFFFFFF, 32'h0000_0000);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hA5A5_A5A5);
        start_sound(24'd10);
        send_word(32'h5A5A_5A5A);
        send_word(32'h3C3C_C3C3);
        start_sound(24'd8);
        send_word(32'h8421_1248);
        start_sound(24'd9);
        send_item(dpcm_pkg::FUNC_WORD, 24'hFFFFFF, 32'h0F0F_F0F0);
        send_item(dpcm_pkg::FUNC_WORD, 24'h000000, 32'hE1D2_C3B4);
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 20; recv_idle_pct = 64; end
                1: begin send_idle_pct = 64; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            drain();
            configure(seg);
            if (seg == 0 || seg == 4)
                hold_request = HOLD_CYCLES;
            seg_start = useful_items;
            while (useful_items - seg_start < SEG_ITEMS)
                run_sound();
        end
        drain();

        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
